/* rtl/text_line_segmenter_macros.svh */
// ----------------------------------------------------------------------------
// text_line_segmenter_macros
// Assertion macros shared by the segmenter RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_SEGMENTER_MACROS_SVH
`define TEXT_LINE_SEGMENTER_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define TLS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("tls assertion failed");
// expression must never be true outside reset
`define TLS_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("tls forbidden condition");
`else
`define TLS_ASSERT(lbl, clk, rstn, prop)
`define TLS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* rtl/tls_pkg.sv */
// ----------------------------------------------------------------------------
// tls_pkg
// Widths, register codes and types of the text line segmenter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tls_pkg;

    localparam int ROW_BITS  = 12;
    localparam int OUT_BITS  = 12;
    localparam int PIX_BITS  = 8;
    localparam int GAP_BITS  = 12;
    localparam int CMP_BITS  = (ROW_BITS > GAP_BITS) ? ROW_BITS : GAP_BITS;

    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INK_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MERGE_GAP     = 1'd1;

    localparam logic [PIX_BITS-1:0] THRESHOLD_RESET = 8'd120;
    localparam logic [GAP_BITS-1:0] GAP_RESET       = 12'd10;

    localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic                last;
        logic [OUT_BITS-1:0] bottom;
        logic [OUT_BITS-1:0] top;
    } t_line;

    // results of one transaction, slot 0 first
    typedef struct packed {
        logic [1:0] count;
        t_line      slot1;
        t_line      slot0;
    } t_res_pair;

    function automatic logic [OUT_BITS-1:0] to_out(input logic [ROW_BITS-1:0] row);
        return OUT_BITS'(row);
    endfunction

endpackage

/* rtl/tls_line_track.sv */
// ----------------------------------------------------------------------------
// tls_line_track
// Row ink detection, run tracking and line merging; produces up to two
// line spans per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_line_segmenter_macros.svh"

module tls_line_track (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tls_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [tls_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_accept,
    input  logic [tls_pkg::PIX_BITS-1:0]        i_pixel,
    input  logic                                i_row_end,
    input  logic                                i_frame_end,
    output tls_pkg::t_res_pair                  o_res
);

    logic [tls_pkg::PIX_BITS-1:0] r_threshold;
    logic [tls_pkg::GAP_BITS-1:0] r_gap;
    logic [tls_pkg::ROW_BITS-1:0] r_row_count, n_row_count;
    logic                         r_row_has_ink, n_row_has_ink;
    logic                         r_run_open, n_run_open;
    logic [tls_pkg::ROW_BITS-1:0] r_run_top, n_run_top;
    logic                         r_pend_valid, n_pend_valid;
    logic [tls_pkg::ROW_BITS-1:0] r_pend_top, n_pend_top;
    logic [tls_pkg::ROW_BITS-1:0] r_pend_bottom, n_pend_bottom;

    logic                         row_done;
    logic                         ink;
    logic                         open_new;
    logic [tls_pkg::ROW_BITS-1:0] top_new;
    logic [tls_pkg::ROW_BITS-1:0] eff_top;
    logic                         do_close;
    logic [tls_pkg::ROW_BITS-1:0] diff;
    logic                         merge;
    logic                         emit_old;
    logic                         emit_pend;
    tls_pkg::t_line               line_old;
    tls_pkg::t_line               line_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= tls_pkg::THRESHOLD_RESET;
            r_gap       <= tls_pkg::GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tls_pkg::CFG_INK_THRESHOLD: r_threshold <= i_cfg_data[tls_pkg::PIX_BITS-1:0];
                tls_pkg::CFG_MERGE_GAP:     r_gap       <= i_cfg_data[tls_pkg::GAP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        row_done = i_row_end | i_frame_end;
        ink      = r_row_has_ink | (i_pixel <= r_threshold);
        open_new = row_done & ink & ~r_run_open;
        top_new  = (r_row_count != '0) ? r_row_count - 1'b1 : '0;
        eff_top  = open_new ? top_new : r_run_top;
        do_close = row_done & ((r_run_open & ~ink) | (i_frame_end & (r_run_open | ink)));
        diff     = eff_top - r_pend_bottom;
        merge    = r_pend_valid & (eff_top >= r_pend_bottom)
                   & (tls_pkg::CMP_BITS'(diff) <= tls_pkg::CMP_BITS'(r_gap));

        n_row_count   = r_row_count;
        n_row_has_ink = r_row_has_ink;
        n_run_open    = r_run_open;
        n_run_top     = r_run_top;
        n_pend_valid  = r_pend_valid;
        n_pend_top    = r_pend_top;
        n_pend_bottom = r_pend_bottom;
        emit_old      = 1'b0;

        if (do_close) begin
            if (merge) begin
                n_pend_bottom = r_row_count;
            end else begin
                emit_old      = r_pend_valid;
                n_pend_valid  = 1'b1;
                n_pend_top    = eff_top;
                n_pend_bottom = r_row_count;
            end
        end

        line_old.top    = tls_pkg::to_out(r_pend_top);
        line_old.bottom = tls_pkg::to_out(r_pend_bottom);
        line_pend.top    = tls_pkg::to_out(n_pend_top);
        line_pend.bottom = tls_pkg::to_out(n_pend_bottom);
        line_pend.last   = 1'b1;

        emit_pend     = row_done & i_frame_end & n_pend_valid;
        line_old.last = ~emit_pend;

        if (row_done) begin
            n_run_top     = eff_top;
            n_run_open    = ink & ~i_frame_end;
            n_row_has_ink = 1'b0;
            if (i_frame_end) begin
                n_row_count  = '0;
                n_pend_valid = 1'b0;
            end else if (r_row_count != tls_pkg::ROW_MAX) begin
                n_row_count = r_row_count + 1'b1;
            end
        end else begin
            n_row_has_ink = ink;
        end

        o_res.count = {1'b0, emit_old} + {1'b0, emit_pend};
        o_res.slot0 = emit_old ? line_old : line_pend;
        o_res.slot1 = line_pend;
        if (!i_accept) begin
            o_res.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= '0;
            r_row_has_ink <= 1'b0;
            r_run_open    <= 1'b0;
            r_run_top     <= '0;
            r_pend_valid  <= 1'b0;
            r_pend_top    <= '0;
            r_pend_bottom <= '0;
        end else if (i_accept) begin
            r_row_count   <= n_row_count;
            r_row_has_ink <= n_row_has_ink;
            r_run_open    <= n_run_open;
            r_run_top     <= n_run_top;
            r_pend_valid  <= n_pend_valid;
            r_pend_top    <= n_pend_top;
            r_pend_bottom <= n_pend_bottom;
        end
    end

    `TLS_ASSERT(a_frame_clears, i_clk, i_rst_n, (i_accept && i_frame_end) |=> (!r_pend_valid && !r_run_open && r_row_count == '0))
    `TLS_ASSERT_NEVER(a_two_no_frame, i_clk, i_rst_n, o_res.count == 2'd2 && !i_frame_end)
    `TLS_ASSERT(a_open_has_pend_or_new, i_clk, i_rst_n, (i_accept && do_close) |=> r_pend_valid || $past(i_frame_end))

endmodule

/* rtl/tls_out_fifo.sv */
// ----------------------------------------------------------------------------
// tls_out_fifo
// Small result queue taking up to two line spans per cycle and delivering
// one per cycle on the output stream while i_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_line_segmenter_macros.svh"

module tls_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tls_pkg::t_res_pair  i_res,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output tls_pkg::t_line      o_line
);

    tls_pkg::t_line                  r_mem [tls_pkg::FIFO_DEPTH];
    logic [tls_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [tls_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [tls_pkg::FIFO_CNT_W-1:0]  r_count;
    logic [tls_pkg::FIFO_PTR_W-1:0]  wr_ptr1;
    logic                            pop;

    assign pop     = o_valid & i_ready;
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= tls_pkg::FIFO_CNT_W'(tls_pkg::FIFO_DEPTH - 2));
    assign o_line  = r_mem[r_rd_ptr];
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res.slot0;
        end
        if (i_res.count == 2'd2) begin
            r_mem[wr_ptr1] <= i_res.slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + tls_pkg::FIFO_PTR_W'(i_res.count);
            r_rd_ptr <= r_rd_ptr + tls_pkg::FIFO_PTR_W'(pop);
            r_count  <= r_count + tls_pkg::FIFO_CNT_W'(i_res.count)
                        - tls_pkg::FIFO_CNT_W'(pop);
        end
    end

    `TLS_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_res.count != 2'd0 && !o_room)
    `TLS_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > tls_pkg::FIFO_CNT_W'(tls_pkg::FIFO_DEPTH))
    `TLS_ASSERT(a_ptr_gap, i_clk, i_rst_n, tls_pkg::FIFO_PTR_W'(r_wr_ptr - r_rd_ptr) == r_count[tls_pkg::FIFO_PTR_W-1:0])

endmodule

/* rtl/text_line_segmenter.sv */
// ----------------------------------------------------------------------------
// text_line_segmenter
// Horizontal projection line segmentation of a gray pixel stream.
//
//   channel   dir  fields (low bit up)
//   s_axis    in   tdata: pixel[7:0]; tuser: row_end; tlast: frame_end
//   m_axis    out  tdata: line_top[11:0], line_bottom[23:12]; tlast: last
//   cfg       in   i_cfg_addr 0: ink_threshold[7:0], 1: merge_gap[11:0]
//
// One pixel per clock while s_axis_tready is high; state updates when accepted.
// Line spans go through a 4-entry queue; s_axis_tready drops only while
// fewer than two queue entries are free.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_segmenter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tls_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [tls_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // pixel
    input  logic                                s_axis_tuser,   // row_end
    input  logic                                s_axis_tlast,   // frame_end
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,   // line_top, line_bottom
    output logic                                m_axis_tlast    // last
);

    tls_pkg::t_res_pair res;
    tls_pkg::t_line     line;
    logic               room;
    logic               accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid & room;

    tls_line_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (s_axis_tdata[tls_pkg::PIX_BITS-1:0]),
        .i_row_end   (s_axis_tuser),
        .i_frame_end (s_axis_tlast),
        .o_res       (res)
    );

    tls_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_line  (line)
    );

    assign m_axis_tdata = {line.bottom, line.top};
    assign m_axis_tlast = line.last;

endmodule

/* tb/sv/text_line_segmenter_tb.sv */
// ----------------------------------------------------------------------------
// text_line_segmenter_tb
// Self-checking bench for the line segmenter. Pixel frames go in over the
// input stream and every line span coming out is compared field by field
// against a behavioral line tracker kept inside the bench. It covers directed
// corner frames, output backpressure and randomized frames under several
// threshold and merge gap settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_line_segmenter_tb;

    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic [tls_pkg::OUT_BITS-1:0] top;
        logic [tls_pkg::OUT_BITS-1:0] bottom;
        logic                         last;
    } t_span;

    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              i_cfg_we      = 1'b0;
    logic [tls_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr    = '0;
    logic [tls_pkg::CFG_DATA_BITS-1:0] i_cfg_data    = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [7:0]                        s_axis_tdata  = '0;   // pixel
    logic                              s_axis_tuser  = 1'b0; // row_end
    logic                              s_axis_tlast  = 1'b0; // frame_end
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [23:0]                       m_axis_tdata;         // line_top, line_bottom
    logic                              m_axis_tlast;         // last

    text_line_segmenter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // line tracker state
    logic [tls_pkg::PIX_BITS-1:0] thr_cfg;
    logic [tls_pkg::GAP_BITS-1:0] gap_cfg;
    logic [tls_pkg::ROW_BITS-1:0] row_idx;
    bit                           row_ink;
    bit                           run_active;
    logic [tls_pkg::ROW_BITS-1:0] run_start;
    bit                           line_open;
    logic [tls_pkg::ROW_BITS-1:0] line_top_r;
    logic [tls_pkg::ROW_BITS-1:0] line_bot_r;

    t_span step_q[$];
    t_span span_q[$];

    int mismatches  = 0;
    int pixels_sent = 0;
    int tx_idle_max = 10;
    int rx_idle_max = 10;
    int rx_hold     = 0;
    int quiet       = 0;

    function automatic void emit_span(input logic [tls_pkg::ROW_BITS-1:0] top,
                                      input logic [tls_pkg::ROW_BITS-1:0] bottom);
        t_span s;
        s.top    = top[tls_pkg::OUT_BITS-1:0];
        s.bottom = bottom[tls_pkg::OUT_BITS-1:0];
        s.last   = 1'b0;
        step_q.insert(step_q.size(), s);
    endfunction

    function automatic void close_span(input logic [tls_pkg::ROW_BITS-1:0] top,
                                       input logic [tls_pkg::ROW_BITS-1:0] bottom);
        if (line_open && top >= line_bot_r && (top - line_bot_r) <= gap_cfg) begin
            line_bot_r = bottom;
        end else begin
            if (line_open)
                emit_span(line_top_r, line_bot_r);
            line_open  = 1'b1;
            line_top_r = top;
            line_bot_r = bottom;
        end
    endfunction

    function automatic void segment_pixel(input logic [7:0] pix, input logic row_end,
                                          input logic frame_end);
        logic                         row_done;
        logic [tls_pkg::ROW_BITS-1:0] r;
        t_span                        s;
        row_done = row_end | frame_end;
        if (pix <= thr_cfg)
            row_ink = 1'b1;
        if (row_done) begin
            r = row_idx;
            if (row_ink && !run_active) begin
                run_active = 1'b1;
                run_start  = (r > 0) ? r - 1'b1 : '0;
            end else if (!row_ink && run_active) begin
                close_span(run_start, r);
                run_active = 1'b0;
            end
            if (frame_end) begin
                if (run_active) begin
                    close_span(run_start, r);
                    run_active = 1'b0;
                end
                if (line_open) begin
                    emit_span(line_top_r, line_bot_r);
                    line_open = 1'b0;
                end
                row_idx = '0;
            end else if (r != tls_pkg::ROW_MAX) begin
                row_idx = r + 1'b1;
            end
            row_ink = 1'b0;
        end
        foreach (step_q[i]) begin
            s      = step_q[i];
            s.last = (i == step_q.size() - 1);
            span_q.insert(span_q.size(), s);
        end
        step_q.delete();
    endfunction

    function automatic logic [7:0] ink_level();
        return 8'($urandom_range(0, int'(thr_cfg)));
    endfunction

    function automatic logic [7:0] blank_level();
        return (thr_cfg == 8'hFF) ? 8'hFF : 8'($urandom_range(int'(thr_cfg) + 1, 255));
    endfunction

    task automatic send_pixel(input logic [7:0] pix, input logic row_end,
                              input logic frame_end);
        int gap_cycles;
        gap_cycles = (tx_idle_max == 0) ? 0 : $urandom_range(0, tx_idle_max);
        if (gap_cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= row_end;
        s_axis_tlast  <= frame_end;
        do @(posedge i_clk); while (!s_axis_tready);
        segment_pixel(pix, row_end, frame_end);
        pixels_sent++;
    endtask

    task automatic send_row(input int width, input bit ink, input bit frame_end,
                            input bit noise);
        int         dark_pos;
        logic [7:0] pix;
        bit         tail;
        dark_pos = $urandom_range(0, width - 1);
        for (int c = 0; c < width; c++) begin
            if (noise)
                pix = 8'($urandom_range(0, 255));
            else if (ink && c == dark_pos)
                pix = ink_level();
            else
                pix = blank_level();
            tail = (c == width - 1);
            send_pixel(pix, tail && (!frame_end || $urandom_range(0, 1) == 1),
                       tail && frame_end);
        end
    endtask

    task automatic send_frame();
        int width;
        int height;
        int empty_left;
        int ink_left;
        int span;
        bit noise;
        width      = $urandom_range(1, 4);
        height     = $urandom_range(1, 30);
        empty_left = $urandom_range(0, 3);
        ink_left   = 0;
        span       = (gap_cfg > 8) ? 8 : int'(gap_cfg);
        for (int row = 0; row < height; row++) begin
            if (empty_left == 0 && ink_left == 0)
                ink_left = $urandom_range(1, 4);
            noise = ($urandom_range(0, 19) == 0);
            send_row(width, ink_left > 0, row == height - 1, noise);
            if (ink_left > 0) begin
                ink_left--;
                if (ink_left == 0)
                    empty_left = $urandom_range(1, span + 3);
            end else begin
                empty_left--;
            end
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (span_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [tls_pkg::CFG_ADDR_BITS-1:0] addr,
                             input logic [tls_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (addr == tls_pkg::CFG_INK_THRESHOLD)
            thr_cfg = data[tls_pkg::PIX_BITS-1:0];
        else
            gap_cfg = data[tls_pkg::GAP_BITS-1:0];
    endtask

    task automatic configure(input int thr, input int gap);
        drain();
        cfg_write(tls_pkg::CFG_INK_THRESHOLD, tls_pkg::CFG_DATA_BITS'(thr));
        cfg_write(tls_pkg::CFG_MERGE_GAP, tls_pkg::CFG_DATA_BITS'(gap));
        i_cfg_we <= 1'b0;
    endtask

    // reset values: boundary level, merge of two runs, open run at frame end
    task automatic test_reset_defaults();
        send_pixel(8'd120, 1'b1, 1'b0);
        send_pixel(8'd121, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd0,   1'b1, 1'b0);
        send_pixel(8'd200, 1'b1, 1'b0);
        send_pixel(8'd50,  1'b0, 1'b1);
    endtask

    // zero gap: merge at distance 0, displacement, two spans on one frame end
    task automatic test_zero_gap();
        configure(0, 0);
        send_pixel(8'd0,   1'b1, 1'b0);
        send_pixel(8'd1,   1'b1, 1'b0);
        send_pixel(8'd0,   1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd128, 1'b1, 1'b0);
        send_pixel(8'd0,   1'b0, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd0,   1'b0, 1'b1);
    endtask

    task automatic test_extremes();
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd1,   1'b1, 1'b1);
        configure(255, 4095);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd7,   1'b1, 1'b0);
        send_pixel(8'd128, 1'b0, 1'b1);
        send_pixel(8'd255, 1'b0, 1'b1);
    endtask

    task automatic test_backpressure();
        configure(120, 0);
        tx_idle_max = 0;
        rx_hold     = 300;
        for (int k = 0; k < 12; k++) begin
            send_pixel(ink_level(), 1'b1, 1'b0);
            send_pixel(blank_level(), 1'b1, 1'b0);
            send_pixel(blank_level(), 1'b1, 1'b0);
        end
        send_pixel(blank_level(), 1'b1, 1'b1);
        tx_idle_max = 10;
    endtask

    task automatic test_random_frames(input int thr, input int gap, input int tx_max,
                                      input int rx_max, input int count);
        int start;
        configure(thr, gap);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        start       = pixels_sent;
        while (pixels_sent - start < count)
            send_frame();
    endtask

    initial begin
        thr_cfg    = tls_pkg::THRESHOLD_RESET;
        gap_cfg    = tls_pkg::GAP_RESET;
        row_idx    = '0;
        row_ink    = 1'b0;
        run_active = 1'b0;
        run_start  = '0;
        line_open  = 1'b0;
        line_top_r = '0;
        line_bot_r = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_gap();
        test_extremes();
        test_backpressure();
        test_random_frames(120, 10, 10, 10, 50);
        test_random_frames(0, 0, 10, 0, 50);
        test_random_frames(255, 4095, 0, 10, 40);
        test_random_frames($urandom_range(0, 255), $urandom_range(0, 6), 0, 0, 50);
        test_random_frames($urandom_range(1, 254), $urandom_range(0, 4), 10, 10, 60);

        drain();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // output side ready pattern
    initial begin
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = (rx_idle_max == 0) ? 0 : $urandom_range(0, rx_idle_max);
            if (rx_hold > 0) begin
                n       = rx_hold;
                rx_hold = 0;
            end
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin : check_spans
        t_span want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (span_q.size() == 0) begin
                $display("%0t: unexpected span top=%0d bottom=%0d last=%0b", $time,
                         m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tlast);
                mismatches++;
            end else begin
                want = span_q[0];
                span_q.delete(0);
                if (m_axis_tdata[11:0] !== want.top) begin
                    $display("%0t: line_top expected %0d actual %0d", $time,
                             want.top, m_axis_tdata[11:0]);
                    mismatches++;
                end
                if (m_axis_tdata[23:12] !== want.bottom) begin
                    $display("%0t: line_bottom expected %0d actual %0d", $time,
                             want.bottom, m_axis_tdata[23:12]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d spans outstanding",
                     $time, quiet, span_q.size());
            $display("FAIL");
            $finish;
        end
    end

endmodule

/* files.f */
+incdir+rtl
rtl/tls_pkg.sv
rtl/tls_line_track.sv
rtl/tls_out_fifo.sv
rtl/text_line_segmenter.sv
tb/sv/text_line_segmenter_tb.sv
